FILE: rtl/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and codes for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_MASK    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_CLOSED  = 3'd5;

	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	localparam logic [1:0] KIND_TEXT  = 2'd0;
	localparam logic [1:0] KIND_PING  = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	typedef struct packed {
		logic       emit;
		logic [1:0] kind;
		logic [7:0] data;
		logic       has;
		logic       eof;
	} wsdf_result_t;

endpackage

FILE: rtl/wsdf_parse.sv
// ----------------------------------------------------------------------------
// wsdf_parse
// Frame header walker and payload unmasker; one byte per fire.
// ----------------------------------------------------------------------------
module wsdf_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            rx_byte,
	output wsdf_pkg::wsdf_result_t res
);

	logic [2:0]  phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        mask_q, mask_d;
	logic [63:0] rem_q, rem_d;
	logic [2:0]  hcnt_q, hcnt_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  midx_q, midx_d;

	always_comb begin
		logic        do_hdr;
		logic [63:0] hdr_rem;
		logic        is_tp;
		logic        last;
		logic [7:0]  kbyte;
		phase_d  = phase_q;
		opcode_d = opcode_q;
		mask_d   = mask_q;
		rem_d    = rem_q;
		hcnt_d   = hcnt_q;
		key_d    = key_q;
		midx_d   = midx_q;
		res      = '0;
		do_hdr   = 1'b0;
		hdr_rem  = rem_q;
		is_tp    = (opcode_q == wsdf_pkg::OP_TEXT) || (opcode_q == wsdf_pkg::OP_PING);
		last     = (rem_q == 64'd1);
		case (midx_q)
			2'd0: kbyte = key_q[31:24];
			2'd1: kbyte = key_q[23:16];
			2'd2: kbyte = key_q[15:8];
			default: kbyte = key_q[7:0];
		endcase
		case (phase_q)
			wsdf_pkg::PH_HDR0: begin
				opcode_d = rx_byte[3:0];
				phase_d  = wsdf_pkg::PH_HDR1;
			end
			wsdf_pkg::PH_HDR1: begin
				mask_d = rx_byte[7];
				if (rx_byte[6:0] == wsdf_pkg::LEN_EXT16 ||
						rx_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
					rem_d   = '0;
					hcnt_d  = (rx_byte[6:0] == wsdf_pkg::LEN_EXT16) ? 3'd1 : 3'd7;
					phase_d = wsdf_pkg::PH_EXTLEN;
				end else begin
					rem_d = {57'd0, rx_byte[6:0]};
					if (rx_byte[7]) begin
						phase_d = wsdf_pkg::PH_MASK;
						hcnt_d  = 3'd3;
						key_d   = '0;
					end else begin
						do_hdr  = 1'b1;
						hdr_rem = {57'd0, rx_byte[6:0]};
					end
				end
			end
			wsdf_pkg::PH_EXTLEN: begin
				rem_d = {rem_q[55:0], rx_byte};
				if (hcnt_q == 3'd0) begin
					if (mask_q) begin
						phase_d = wsdf_pkg::PH_MASK;
						hcnt_d  = 3'd3;
						key_d   = '0;
					end else begin
						do_hdr  = 1'b1;
						hdr_rem = {rem_q[55:0], rx_byte};
					end
				end else begin
					hcnt_d = hcnt_q - 3'd1;
				end
			end
			wsdf_pkg::PH_MASK: begin
				key_d = {key_q[23:0], rx_byte};
				if (hcnt_q == 3'd0) begin
					do_hdr = 1'b1;
				end else begin
					hcnt_d = hcnt_q - 3'd1;
				end
			end
			wsdf_pkg::PH_PAYLOAD: begin
				midx_d = midx_q + 2'd1;
				rem_d  = rem_q - 64'd1;
				if (is_tp) begin
					res.emit = 1'b1;
					res.kind = (opcode_q == wsdf_pkg::OP_TEXT) ?
						wsdf_pkg::KIND_TEXT : wsdf_pkg::KIND_PING;
					res.data = rx_byte ^ (mask_q ? kbyte : 8'd0);
					res.has  = 1'b1;
					res.eof  = last;
					if (last) begin
						phase_d = wsdf_pkg::PH_HDR0;
					end
				end else if (last) begin
					if (opcode_q == wsdf_pkg::OP_CLOSE) begin
						phase_d  = wsdf_pkg::PH_CLOSED;
						res.emit = 1'b1;
						res.kind = wsdf_pkg::KIND_CLOSE;
						res.eof  = 1'b1;
					end else begin
						phase_d = wsdf_pkg::PH_HDR0;
					end
				end
			end
			default: begin
			end
		endcase
		if (do_hdr) begin
			if (hdr_rem != 64'd0) begin
				phase_d = wsdf_pkg::PH_PAYLOAD;
				midx_d  = 2'd0;
			end else if (is_tp) begin
				phase_d  = wsdf_pkg::PH_HDR0;
				res.emit = 1'b1;
				res.kind = (opcode_q == wsdf_pkg::OP_TEXT) ?
					wsdf_pkg::KIND_TEXT : wsdf_pkg::KIND_PING;
				res.eof  = 1'b1;
			end else if (opcode_q == wsdf_pkg::OP_CLOSE) begin
				phase_d  = wsdf_pkg::PH_CLOSED;
				res.emit = 1'b1;
				res.kind = wsdf_pkg::KIND_CLOSE;
				res.eof  = 1'b1;
			end else begin
				phase_d = wsdf_pkg::PH_HDR0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsdf_pkg::PH_HDR0;
			opcode_q <= '0;
			mask_q   <= 1'b0;
			rem_q    <= '0;
			hcnt_q   <= '0;
			key_q    <= '0;
			midx_q   <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			mask_q   <= mask_d;
			rem_q    <= rem_d;
			hcnt_q   <= hcnt_d;
			key_q    <= key_d;
			midx_q   <= midx_d;
		end
	end

`ifndef SYNTHESIS
	a_closed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wsdf_pkg::PH_CLOSED) |-> !res.emit)
		else $error("result produced after close");
	a_closed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wsdf_pkg::PH_CLOSED) |=> (phase_q == wsdf_pkg::PH_CLOSED))
		else $error("left closed phase");
	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wsdf_pkg::PH_PAYLOAD) |-> (rem_q != 64'd0))
		else $error("payload phase with zero count");
`endif

endmodule

FILE: rtl/wsdf_out.sv
// ----------------------------------------------------------------------------
// wsdf_out
// Result register holding one item until the consumer takes it.
// ----------------------------------------------------------------------------
module wsdf_out (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  wsdf_pkg::wsdf_result_t res,
	input  logic                  out_stall,
	output logic                  room,
	output logic                  out_valid,
	output logic [1:0]            frame_kind,
	output logic [7:0]            payload_byte,
	output logic                  has_byte,
	output logic                  end_of_frame
);

	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] data_q;
	logic       has_q;
	logic       eof_q;

	assign room = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (room && load) begin
			kind_q <= res.kind;
			data_q <= res.data;
			has_q  <= res.has;
			eof_q  <= res.eof;
		end
	end

	assign out_valid    = valid_q;
	assign frame_kind   = kind_q;
	assign payload_byte = data_q;
	assign has_byte     = has_q;
	assign end_of_frame = eof_q;

endmodule

FILE: rtl/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Receive-side WebSocket frame parser with payload unmasking.
// ----------------------------------------------------------------------------
// One received byte per item, one item per clock when the output is drained.
// Each byte is registered, walked through the header/payload state
// combinationally, and any result lands in the output register. Header
// bytes (but the last one of an empty frame) and dropped frames give no
// result and never wait on the output side. Text and ping payload bytes
// come out unmasked; empty text and ping frames give a marker; a close
// frame gives one close item and all later bytes are swallowed until reset.
module websocket_frame_deframer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] frame_kind,
	output logic [7:0] payload_byte,
	output logic       has_byte,
	output logic       end_of_frame
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   room;
	logic                   advance;
	wsdf_pkg::wsdf_result_t res;

	assign advance  = valid_s1 && (!res.emit || room);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	wsdf_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	wsdf_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && res.emit),
		.res          (res),
		.out_stall    (out_stall),
		.room         (room),
		.out_valid    (out_valid),
		.frame_kind   (frame_kind),
		.payload_byte (payload_byte),
		.has_byte     (has_byte),
		.end_of_frame (end_of_frame)
	);

`ifndef SYNTHESIS
	a_marker_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte) |-> (end_of_frame && payload_byte == 8'd0))
		else $error("marker item not closing a frame");
	a_close_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_kind == wsdf_pkg::KIND_CLOSE) |-> !has_byte)
		else $error("close item carries a byte");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res.emit && out_valid && out_stall) |-> in_stall)
		else $error("result would overwrite a held item");
`endif

endmodule
